// File: rtl/core/jsu_pkg.sv
// shared types, codes and helper functions for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

    // decoder modes
    typedef enum logic [2:0] {
        MODE_PLAIN    = 3'd0,
        MODE_ESC      = 3'd1,
        MODE_HEX      = 3'd2,
        MODE_HIGH     = 3'd3,
        MODE_HIGH_ESC = 3'd4,
        MODE_LOW_HEX  = 3'd5
    } mode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_CONT        = 3'd0,
        ST_CLOSED      = 3'd1,
        ST_UNTERM_STR  = 3'd2,
        ST_UNTERM_ESC  = 3'd3,
        ST_BAD_U       = 3'd4,
        ST_UNKNOWN_ESC = 3'd5
    } status_t;

    // what the main part of a command emits
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RAW  = 2'd1,
        KIND_CP   = 2'd2
    } kind_t;

    // one decoded item as handed from the front to the back
    typedef struct packed {
        logic          fffd;    // replacement character goes out first
        kind_t         kind;
        logic [20:0]   value;   // raw byte in [7:0] or a code point
        status_t       status;  // closing or error beat goes out last
    } cmd_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] CP_FFFD    = 21'h00FFFD;
    // 0x10000 expressed in units of the 10-bit low half
    localparam logic [10:0] SUPP_BASE  = 11'h040;

    // utf-8 form of u+fffd
    localparam logic [2:0][7:0] FFFD_UTF8 = {8'hBD, 8'hBF, 8'hEF};

    // hex digit value, bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // single-letter escape, bit 8 set when the letter is known
    function automatic logic [8:0] escape_byte(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            CH_QUOTE: r = {1'b1, CH_QUOTE};
            CH_BSL:   r = {1'b1, CH_BSL};
            CH_SLASH: r = {1'b1, CH_SLASH};
            CH_B:     r = {1'b1, 8'h08};
            CH_F:     r = {1'b1, 8'h0C};
            CH_N:     r = {1'b1, 8'h0A};
            CH_R:     r = {1'b1, 8'h0D};
            CH_T:     r = {1'b1, 8'h09};
            default:  r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/jsu_in_if.sv
// input channel: one raw string byte per beat
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// File: rtl/core/jsu_out_if.sv
// output channel: one decoded byte or status per beat
`timescale 1ns / 1ps

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input last, output ready);
endinterface

// File: rtl/core/jsu_front.sv
// front end: escape decoding state machine, one input beat per cycle while the queue is not full
`timescale 1ns / 1ps

module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    jsu_in_if.sink          text,
    output logic            cmd_push,
    output jsu_pkg::cmd_t   cmd,
    input  logic            cmd_full
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  pend_reg, pend_next;

    logic        accept;
    logic [4:0]  hexd;
    logic [8:0]  esc;
    logic [15:0] acc_shift;
    logic        is_high, is_low;

    assign text.ready = !cmd_full;
    assign accept     = text.valid && text.ready;

    assign hexd      = hex_value(text.in_byte);
    assign esc       = escape_byte(text.in_byte);
    assign acc_shift = {acc_reg[11:0], hexd[3:0]};
    assign is_high   = acc_shift >= HIGH_FIRST && acc_shift <= HIGH_LAST;
    assign is_low    = acc_shift >= LOW_FIRST && acc_shift <= LOW_LAST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        cmd.fffd   = 1'b0;
        cmd.kind   = KIND_NONE;
        cmd.value  = '0;
        cmd.status = ST_CONT;

        if (text.end_of_input)
        begin
            cmd.fffd = mode_reg == MODE_HIGH || mode_reg == MODE_HIGH_ESC
                       || mode_reg == MODE_LOW_HEX;
            unique case (mode_reg) inside
                MODE_PLAIN, MODE_HIGH:   cmd.status = ST_UNTERM_STR;
                MODE_ESC, MODE_HIGH_ESC: cmd.status = ST_UNTERM_ESC;
                default:                 cmd.status = ST_BAD_U;
            endcase
            mode_next = MODE_PLAIN;
            acc_next  = '0;
            cnt_next  = '0;
            pend_next = '0;
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_ESC, MODE_HIGH_ESC:
                begin
                    if (text.in_byte == CH_U)
                    begin
                        mode_next = (mode_reg == MODE_ESC) ? MODE_HEX : MODE_LOW_HEX;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        // a pending high surrogate is dropped before the letter
                        cmd.fffd  = mode_reg == MODE_HIGH_ESC;
                        pend_next = '0;
                        if (esc[8])
                        begin
                            cmd.kind  = KIND_RAW;
                            cmd.value = {13'd0, esc[7:0]};
                            mode_next = MODE_PLAIN;
                        end
                        else
                        begin
                            cmd.status = ST_UNKNOWN_ESC;
                            mode_next  = MODE_PLAIN;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                    end
                end
                MODE_HEX, MODE_LOW_HEX:
                begin
                    if (!hexd[4])
                    begin
                        cmd.fffd   = mode_reg == MODE_LOW_HEX;
                        cmd.status = ST_BAD_U;
                        mode_next  = MODE_PLAIN;
                        acc_next   = '0;
                        cnt_next   = '0;
                        pend_next  = '0;
                    end
                    else if (cnt_reg != 2'd3)
                    begin
                        acc_next = acc_shift;
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else if (mode_reg == MODE_LOW_HEX && is_low)
                    begin
                        // surrogate pair joined into one supplementary code point
                        cmd.kind  = KIND_CP;
                        cmd.value = {{1'b0, pend_reg} + SUPP_BASE, acc_shift[9:0]};
                        mode_next = MODE_PLAIN;
                        acc_next  = '0;
                        cnt_next  = '0;
                        pend_next = '0;
                    end
                    else
                    begin
                        // fresh value, after dropping any unpaired high surrogate
                        cmd.fffd = mode_reg == MODE_LOW_HEX;
                        acc_next = '0;
                        cnt_next = '0;
                        if (is_high)
                        begin
                            pend_next = acc_shift[9:0];
                            mode_next = MODE_HIGH;
                        end
                        else
                        begin
                            pend_next = '0;
                            cmd.kind  = KIND_CP;
                            cmd.value = is_low ? CP_FFFD : {5'd0, acc_shift};
                            mode_next = MODE_PLAIN;
                        end
                    end
                end
                default:
                begin
                    // plain text, or a high surrogate waiting for its pair
                    if (text.in_byte == CH_BSL)
                    begin
                        mode_next = (mode_reg == MODE_HIGH) ? MODE_HIGH_ESC : MODE_ESC;
                    end
                    else
                    begin
                        cmd.fffd  = mode_reg == MODE_HIGH;
                        pend_next = '0;
                        mode_next = MODE_PLAIN;
                        if (text.in_byte == CH_QUOTE)
                        begin
                            cmd.status = ST_CLOSED;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            cmd.kind  = KIND_RAW;
                            cmd.value = {13'd0, text.in_byte};
                        end
                    end
                end
            endcase
        end
    end

    assign cmd_push = accept && (cmd.fffd || cmd.kind != KIND_NONE || cmd.status != ST_CONT);

endmodule

// File: rtl/core/jsu_queue.sv
// command queue between the decoder and the byte serialiser
`timescale 1ns / 1ps

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::cmd_t   push_cmd,
    output logic            full,
    output logic            head_valid,
    output jsu_pkg::cmd_t   head,
    input  logic            pop
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next    = do_push ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1)) : wr_reg;
        rd_next    = do_pop ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1)) : rd_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/jsu_back.sv
// back end: expands a command into result beats, one per cycle while the output is taken
`timescale 1ns / 1ps

module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  jsu_pkg::cmd_t   head,
    output logic            pop,
    jsu_out_if.source       result
);
    import jsu_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    utf8_t      enc;
    logic [2:0] main_len;
    logic [2:0] fffd_len;
    logic [3:0] total;
    logic [2:0] j;
    logic [7:0] beat_byte;
    logic       beat_bvalid;
    logic [2:0] beat_status;
    logic       beat_last;
    logic       load;

    assign enc      = utf8_encode(head.value);
    assign fffd_len = head.fffd ? 3'd3 : 3'd0;
    assign total    = {1'b0, fffd_len} + {1'b0, main_len} + {3'd0, head.status != ST_CONT};
    assign j        = idx_reg - fffd_len;

    always_comb
    begin
        case (head.kind)
            KIND_RAW: main_len = 3'd1;
            KIND_CP:  main_len = enc.len;
            default:  main_len = 3'd0;
        endcase

        beat_byte   = '0;
        beat_bvalid = 1'b0;
        beat_status = ST_CONT;
        if (head.fffd && idx_reg < 3'd3)
        begin
            beat_byte   = FFFD_UTF8[idx_reg[1:0]];
            beat_bvalid = 1'b1;
        end
        else if (j < main_len)
        begin
            beat_byte   = (head.kind == KIND_RAW) ? head.value[7:0] : enc.bytes[j[1:0]];
            beat_bvalid = 1'b1;
        end
        else
        begin
            beat_status = head.status;
        end
    end

    assign beat_last = {1'b0, idx_reg} == total - 4'd1;
    assign load      = head_valid && (!valid_reg || result.ready);
    assign pop       = load && beat_last;
    assign idx_next  = pop ? '0 : (load ? idx_reg + 3'd1 : idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= beat_byte;
            bvalid_reg <= beat_bvalid;
            status_reg <= beat_status;
            last_reg   <= beat_last;
        end
    end

    assign result.valid      = valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.byte_valid = bvalid_reg;
    assign result.status     = status_reg;
    assign result.last       = last_reg;

endmodule

// File: rtl/core/json_string_unescape_to_utf8.sv
// top level of the json string unescaper with utf-8 output
`timescale 1ns / 1ps

// Takes the body of a JSON string one byte per beat, starting after the opening
// quote, and gives the unescaped text as UTF-8 bytes, one byte or one status per
// result beat; last marks the final beat caused by an input beat. Plain bytes pass
// through, the short escapes give the byte they name, \uXXXX becomes UTF-8,
// a surrogate pair is joined into one code point and any unpaired surrogate turns
// into U+FFFD. A closing quote gives status 1; end_of_input or a malformed escape
// gives an error status; either way the block is then ready for a new string.
// An input beat that only advances an escape gives no result beat at all.
// Rate: the decoder takes one input beat every cycle while the command queue
// (QUEUE_DEPTH entries) has room. The serialiser gives one result beat per cycle
// while the output is taken, and an item that expands to more than one result beat
// (up to six: a dropped surrogate plus a three-byte character) holds the back
// end until its last beat is loaded; the input stalls only once the queue has filled up.

module json_string_unescape_to_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source result
);
    import jsu_pkg::*;

    // decoder to queue
    logic cmd_push;
    cmd_t cmd;
    logic cmd_full;

    // queue to serialiser
    logic head_valid;
    cmd_t head;
    logic head_pop;

    // escape decoding, one beat per cycle while the queue has room
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .cmd_push (cmd_push),
        .cmd      (cmd),
        .cmd_full (cmd_full)
    );

    // decouples the decoder from multi-byte output sequences
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (cmd_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (head_pop)
    );

    // utf-8 expansion and registered output
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (head_pop),
        .result     (result)
    );

endmodule
